// ===== hdl/pqs_pkg.sv =====
// Shared types and constants of the priority quantum scheduler.
`default_nettype none

package pqs_pkg;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DISP,
		ST_RUN
	} state_t;

	// Item kinds carried on the input tuser
	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Event codes carried on the output tuser
	localparam logic [2:0] EV_DISPATCHED = 3'd0;
	localparam logic [2:0] EV_PREEMPTED  = 3'd1;
	localparam logic [2:0] EV_FINISHED   = 3'd2;
	localparam logic [2:0] EV_RAN        = 3'd3;
	localparam logic [2:0] EV_ADDED      = 3'd4;
	localparam logic [2:0] EV_REJECTED   = 3'd5;
	localparam logic [2:0] EV_IDLE       = 3'd6;

	// Priority levels
	localparam int PRIO_W   = 3;
	localparam int NUM_PRIO = 8;

	// Register map
	localparam logic REG_QUANTUM_LIMIT = 1'b0;
	localparam logic [7:0] QUANTUM_RESET = 8'd5;

	// One queued task as stored in the entry memory
	typedef struct packed {
		logic [7:0]        work;
		logic [PRIO_W-1:0] prio;
		logic [7:0]        id;
	} entry_t;

endpackage

`default_nettype wire

// ===== hdl/priority_quantum_scheduler_unit.sv =====
// Top level of the priority quantum scheduler: queue memories, controller and ports.
`default_nettype none

// Preemptive priority scheduler with a time quantum. Queued tasks live in an entry memory
// and are chained per priority level through a link memory (FIFO order within a level,
// level 0 served first). The running task keeps its memory slot, so preemption relinks it
// without allocating. An add item goes from ST_IDLE through ST_ADD; a tick goes through
// ST_RUN, and first through ST_DISP when it dispatches the head of the queue, because the
// head entry comes from a memory with registered read data. Each result waits in the output
// register until taken, which adds stall cycles under back-pressure. Free slots are handed
// out by a fill count and then a free list, so no clearing pass runs after reset.
module priority_quantum_scheduler_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // task_id[7:0], task_priority[10:8], task_work[18:11]
	input  wire  [0:0]  s_tuser,   // mode[0]
	// Result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // event_task[7:0], work_left[15:8], quantum_used[23:16]
	output logic [2:0]  m_tuser,   // event_res[2:0]
	output logic        m_tlast,
	// Configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = pqs_pkg::PRIO_W;
	localparam int NP = pqs_pkg::NUM_PRIO;

	// Memories and their registered read data
	pqs_pkg::entry_t entry_mem [QUEUE_DEPTH];
	logic [AW-1:0]   link_mem  [QUEUE_DEPTH];
	pqs_pkg::entry_t entry_rd_s1;
	logic [AW-1:0]   link_rd_s1;

	logic            ent_we, ent_re;
	logic [AW-1:0]   ent_waddr, ent_raddr;
	pqs_pkg::entry_t ent_wdata;
	logic            lnk_we, lnk_re;
	logic [AW-1:0]   lnk_waddr, lnk_raddr, lnk_wdata;

	// Controller state
	pqs_pkg::state_t state_q, state_d;

	// Latched item
	logic [7:0]    item_id_q, item_work_q;
	logic [PW-1:0] item_prio_q;

	// Running task
	logic          run_valid_q, run_valid_d;
	logic [7:0]    run_id_q, run_id_d;
	logic [PW-1:0] run_prio_q, run_prio_d;
	logic [7:0]    run_work_q, run_work_d;
	logic [7:0]    run_quant_q, run_quant_d;
	logic [AW-1:0] run_slot_q, run_slot_d;

	// Per-level list pointers and queue bookkeeping
	logic [AW-1:0] head_q [NP];
	logic [AW-1:0] tail_q [NP];
	logic [CW-1:0] cnt_q  [NP];
	logic [CW-1:0] ready_count_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] free_head_q;

	logic [7:0] quantum_limit_q;

	// Output register
	logic [2:0] out_ev_q, out_ev_d;
	logic [7:0] out_task_q, out_task_d;
	logic [7:0] out_work_q, out_work_d;
	logic [7:0] out_quant_q, out_quant_d;
	logic       out_last_q, out_last_d;
	logic       emit;

	// Control strobes
	logic          accept;
	logic          link_en, pop_en, fill_inc, free_pop, free_push;
	logic [AW-1:0] link_slot, alloc_slot;
	logic [PW-1:0] pmin, pidx;
	logic          pidx_busy, fill_open, full;

	// Lowest nonempty level
	always_comb begin
		pmin = '0;
		for (int i = NP - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				pmin = PW'(i);
			end
		end
	end

	assign accept    = s_tvalid && s_tready;
	assign pidx_busy = (cnt_q[pidx] != '0);
	assign fill_open = (fill_q != CW'(QUEUE_DEPTH));
	assign full      = (({1'b0, ready_count_q} + (CW+1)'(run_valid_q))
		>= (CW+1)'(QUEUE_DEPTH));
	assign alloc_slot = fill_open ? fill_q[AW-1:0] : free_head_q;

	// Next state, memory accesses and results
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		ent_we      = 1'b0;
		ent_re      = 1'b0;
		ent_waddr   = run_slot_q;
		ent_raddr   = head_q[pmin];
		ent_wdata   = '{work: run_work_q, prio: run_prio_q, id: run_id_q};
		lnk_we      = 1'b0;
		lnk_re      = 1'b0;
		lnk_waddr   = tail_q[pidx];
		lnk_raddr   = free_head_q;
		lnk_wdata   = run_slot_q;
		link_en     = 1'b0;
		link_slot   = run_slot_q;
		pop_en      = 1'b0;
		fill_inc    = 1'b0;
		free_pop    = 1'b0;
		free_push   = 1'b0;
		run_valid_d = run_valid_q;
		run_id_d    = run_id_q;
		run_prio_d  = run_prio_q;
		run_work_d  = run_work_q;
		run_quant_d = run_quant_q;
		run_slot_d  = run_slot_q;
		emit        = 1'b0;
		out_ev_d    = pqs_pkg::EV_IDLE;
		out_task_d  = '0;
		out_work_d  = '0;
		out_quant_d = '0;
		out_last_d  = 1'b1;
		pidx        = pmin;

		case (state_q)
			pqs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				pidx     = pmin;
				if (s_tvalid) begin
					if (s_tuser[0] == pqs_pkg::MODE_ADD) begin
						// fetch the free list successor in case the fill count is spent
						lnk_re    = 1'b1;
						lnk_raddr = free_head_q;
						state_d   = pqs_pkg::ST_ADD;
					end else if (!run_valid_q && ready_count_q != '0) begin
						ent_re    = 1'b1;
						ent_raddr = head_q[pmin];
						lnk_re    = 1'b1;
						lnk_raddr = head_q[pmin];
						state_d   = pqs_pkg::ST_DISP;
					end else begin
						state_d = pqs_pkg::ST_RUN;
					end
				end
			end

			pqs_pkg::ST_ADD: begin
				pidx = item_prio_q;
				if (!m_tvalid || m_tready) begin
					emit        = 1'b1;
					out_task_d  = item_id_q;
					out_work_d  = item_work_q;
					out_quant_d = '0;
					out_last_d  = 1'b1;
					if (full) begin
						out_ev_d = pqs_pkg::EV_REJECTED;
					end else begin
						out_ev_d  = pqs_pkg::EV_ADDED;
						fill_inc  = fill_open;
						free_pop  = !fill_open;
						ent_we    = 1'b1;
						ent_waddr = alloc_slot;
						ent_wdata = '{work: item_work_q, prio: item_prio_q, id: item_id_q};
						link_en   = 1'b1;
						link_slot = alloc_slot;
						lnk_we    = pidx_busy;
						lnk_waddr = tail_q[pidx];
						lnk_wdata = alloc_slot;
					end
					state_d = pqs_pkg::ST_IDLE;
				end
			end

			pqs_pkg::ST_DISP: begin
				pidx = item_prio_q;
				if (!m_tvalid || m_tready) begin
					pop_en      = 1'b1;
					run_valid_d = 1'b1;
					run_id_d    = entry_rd_s1.id;
					run_prio_d  = entry_rd_s1.prio;
					run_work_d  = entry_rd_s1.work;
					run_quant_d = '0;
					run_slot_d  = head_q[pidx];
					emit        = 1'b1;
					out_ev_d    = pqs_pkg::EV_DISPATCHED;
					out_task_d  = entry_rd_s1.id;
					out_work_d  = entry_rd_s1.work;
					out_quant_d = '0;
					out_last_d  = 1'b0;
					state_d     = pqs_pkg::ST_RUN;
				end
			end

			pqs_pkg::ST_RUN: begin
				pidx = run_prio_q;
				if (!m_tvalid || m_tready) begin
					emit       = 1'b1;
					out_last_d = 1'b1;
					if (!run_valid_q) begin
						out_ev_d = pqs_pkg::EV_IDLE;
					end else if (run_quant_q >= quantum_limit_q) begin
						// quantum spent: relink the slot behind its level
						run_valid_d = 1'b0;
						run_quant_d = '0;
						ent_we      = 1'b1;
						ent_waddr   = run_slot_q;
						link_en     = 1'b1;
						link_slot   = run_slot_q;
						lnk_we      = pidx_busy;
						lnk_waddr   = tail_q[pidx];
						lnk_wdata   = run_slot_q;
						out_ev_d    = pqs_pkg::EV_PREEMPTED;
						out_task_d  = run_id_q;
						out_work_d  = run_work_q;
						out_quant_d = '0;
					end else if (run_work_q == '0) begin
						// done: slot goes back on the free list
						run_valid_d = 1'b0;
						free_push   = 1'b1;
						lnk_we      = 1'b1;
						lnk_waddr   = run_slot_q;
						lnk_wdata   = free_head_q;
						out_ev_d    = pqs_pkg::EV_FINISHED;
						out_task_d  = run_id_q;
						out_work_d  = '0;
						out_quant_d = run_quant_q;
					end else begin
						run_work_d  = run_work_q - 8'd1;
						run_quant_d = run_quant_q + 8'd1;
						out_ev_d    = pqs_pkg::EV_RAN;
						out_task_d  = run_id_q;
						out_work_d  = run_work_q - 8'd1;
						out_quant_d = run_quant_q + 8'd1;
					end
					state_d = pqs_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = pqs_pkg::ST_IDLE;
			end
		endcase
	end

	// Entry and link memories
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_waddr] <= ent_wdata;
		end
		if (ent_re) begin
			entry_rd_s1 <= entry_mem[ent_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			link_mem[lnk_waddr] <= lnk_wdata;
		end
		if (lnk_re) begin
			link_rd_s1 <= link_mem[lnk_raddr];
		end
	end

	// Latched item fields; a tick keeps the level it dispatches from
	always_ff @(posedge clk) begin
		if (accept) begin
			item_id_q   <= s_tdata[7:0];
			item_work_q <= s_tdata[18:11];
			item_prio_q <= (s_tuser[0] == pqs_pkg::MODE_ADD) ? s_tdata[10:8] : pmin;
		end
	end

	// List pointers (payload)
	always_ff @(posedge clk) begin
		if (link_en) begin
			if (!pidx_busy) begin
				head_q[pidx] <= link_slot;
			end
			tail_q[pidx] <= link_slot;
		end
		if (pop_en) begin
			head_q[pidx] <= link_rd_s1;
		end
		if (free_pop) begin
			free_head_q <= link_rd_s1;
		end else if (free_push) begin
			free_head_q <= run_slot_q;
		end
	end

	// Control state and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= pqs_pkg::ST_IDLE;
			for (int i = 0; i < NP; i++) begin
				cnt_q[i] <= '0;
			end
			ready_count_q   <= '0;
			fill_q          <= '0;
			run_valid_q     <= 1'b0;
			run_id_q        <= '0;
			run_prio_q      <= '0;
			run_work_q      <= '0;
			run_quant_q     <= '0;
			run_slot_q      <= '0;
			quantum_limit_q <= pqs_pkg::QUANTUM_RESET;
			m_tvalid        <= 1'b0;
		end else begin
			state_q     <= state_d;
			run_valid_q <= run_valid_d;
			run_id_q    <= run_id_d;
			run_prio_q  <= run_prio_d;
			run_work_q  <= run_work_d;
			run_quant_q <= run_quant_d;
			run_slot_q  <= run_slot_d;
			if (link_en) begin
				cnt_q[pidx]   <= cnt_q[pidx] + CW'(1);
				ready_count_q <= ready_count_q + CW'(1);
			end else if (pop_en) begin
				cnt_q[pidx]   <= cnt_q[pidx] - CW'(1);
				ready_count_q <= ready_count_q - CW'(1);
			end
			if (fill_inc) begin
				fill_q <= fill_q + CW'(1);
			end
			if (psel && penable && pwrite && pready && paddr[2] == pqs_pkg::REG_QUANTUM_LIMIT) begin
				quantum_limit_q <= pwdata[7:0];
			end
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_ev_q    <= out_ev_d;
			out_task_q  <= out_task_d;
			out_work_q  <= out_work_d;
			out_quant_q <= out_quant_d;
			out_last_q  <= out_last_d;
		end
	end

	assign m_tdata = {out_quant_q, out_work_q, out_task_q};
	assign m_tuser = out_ev_q;
	assign m_tlast = out_last_q;

	// Configuration read
	assign pready = 1'b1;
	assign prdata = (paddr[2] == pqs_pkg::REG_QUANTUM_LIMIT) ? {24'd0, quantum_limit_q} : 32'd0;

	// Queue occupancy never exceeds the slot count
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ready_count_q} + (CW+1)'(run_valid_q)) <= (CW+1)'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	// Fill count stops at the depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH))
		else $error("fill count above depth");

	// A dispatch only happens with no running task
	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pqs_pkg::ST_DISP |-> !run_valid_q)
		else $error("dispatch while a task runs");

	// The running task leaves only from the run step
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_valid_q) |-> $past(state_q) == pqs_pkg::ST_RUN)
		else $error("running task dropped outside run step");

	// The queue only grows on an add or a preemption
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ready_count_q > $past(ready_count_q) |->
		($past(state_q) == pqs_pkg::ST_ADD || $past(state_q) == pqs_pkg::ST_RUN))
		else $error("queue grew outside add or preempt");

endmodule

`default_nettype wire

// ===== test/priority_quantum_scheduler_unit_tb.sv =====
// Self-checking testbench for the priority quantum scheduler: directed, random and stall tests.
module priority_quantum_scheduler_unit_tb;

	localparam int QUEUE_DEPTH      = 16;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 8;

	// One expected result item
	typedef struct {
		logic [2:0] ev;
		logic [7:0] tid;
		logic [7:0] work;
		logic [7:0] quantum;
		logic       last;
	} sched_event_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // task_id[7:0], task_priority[10:8], task_work[18:11]
	logic [0:0]  s_tuser;   // mode[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // event_task[7:0], work_left[15:8], quantum_used[23:16]
	logic [2:0]  m_tuser;   // event_res[2:0]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Scheduler mirror: ready queue, running task and quantum limit
	pqs_pkg::entry_t ready_q[$];
	bit              run_valid;
	logic [7:0]      run_id;
	logic [2:0]      run_prio;
	logic [7:0]      run_work;
	logic [7:0]      run_quantum;
	logic [7:0]      quantum_limit = pqs_pkg::QUANTUM_RESET;
	sched_event_t    pending_events[$];

	// Run control and bookkeeping
	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;
	bit sink_hold_req;
	int error_count;
	int adds_sent;
	int ticks_sent;
	int ev_seen[0:6];

	priority_quantum_scheduler_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	// Work amounts stay small so tasks finish; now and then any value
	function automatic logic [7:0] pick_work(input int work_max);
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, work_max));
	endfunction

	// Sorted insert behind every task of equal or better priority
	function automatic void queue_task(input logic [7:0] id, input logic [2:0] prio,
		input logic [7:0] work);
		int pos;
		pos = ready_q.size();
		while (pos > 0 && ready_q[pos-1].prio > prio)
			pos--;
		ready_q.insert(pos, '{work: work, prio: prio, id: id});
	endfunction

	// Advance the mirror by one accepted item and queue the results it causes
	function automatic void schedule_step(input logic mode, input logic [7:0] id,
		input logic [2:0] prio, input logic [7:0] work);
		sched_event_t    evs[$];
		pqs_pkg::entry_t head;
		if (mode == pqs_pkg::MODE_ADD) begin
			if (ready_q.size() + int'(run_valid) >= QUEUE_DEPTH) begin
				evs.push_back('{pqs_pkg::EV_REJECTED, id, work, 8'd0, 1'b0});
			end else begin
				queue_task(id, prio, work);
				evs.push_back('{pqs_pkg::EV_ADDED, id, work, 8'd0, 1'b0});
			end
		end else begin
			// dispatch the head when nothing runs
			if (!run_valid && ready_q.size() > 0) begin
				head = ready_q.pop_front();
				run_valid = 1'b1;
				run_id = head.id;
				run_prio = head.prio;
				run_work = head.work;
				run_quantum = 8'd0;
				evs.push_back('{pqs_pkg::EV_DISPATCHED, run_id, run_work, 8'd0, 1'b0});
			end
			if (run_valid) begin
				if (run_quantum >= quantum_limit) begin
					run_quantum = 8'd0;
					run_valid = 1'b0;
					queue_task(run_id, run_prio, run_work);
					evs.push_back('{pqs_pkg::EV_PREEMPTED, run_id, run_work, 8'd0, 1'b0});
				end else if (run_work == 8'd0) begin
					run_valid = 1'b0;
					evs.push_back('{pqs_pkg::EV_FINISHED, run_id, 8'd0, run_quantum, 1'b0});
				end else begin
					run_work = run_work - 8'd1;
					run_quantum = run_quantum + 8'd1;
					evs.push_back('{pqs_pkg::EV_RAN, run_id, run_work, run_quantum, 1'b0});
				end
			end
			if (evs.size() == 0)
				evs.push_back('{pqs_pkg::EV_IDLE, 8'd0, 8'd0, 8'd0, 1'b0});
		end
		evs[evs.size()-1].last = 1'b1;
		foreach (evs[i])
			pending_events.push_back(evs[i]);
	endfunction

	// Offer one item after an optional gap; predict once it is taken
	task automatic send_item(input logic mode, input logic [7:0] id, input logic [2:0] prio,
		input logic [7:0] work);
		int gap;
		gap = 0;
		if (src_idle_en && $urandom_range(0, 99) < 30)
			gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {5'd0, work, prio, id};
		do @(posedge clk); while (!s_tready);
		schedule_step(mode, id, prio, work);
		if (mode == pqs_pkg::MODE_ADD)
			adds_sent++;
		else
			ticks_sent++;
	endtask

	task automatic send_random_item(input int add_pct, input int work_max);
		if ($urandom_range(0, 99) < add_pct)
			send_item(pqs_pkg::MODE_ADD, 8'($urandom_range(0, 255)),
				3'($urandom_range(0, 7)), pick_work(work_max));
		else
			send_item(pqs_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
				3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
	endtask

	// Stop offering and wait until every expected result has come
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register access: setup cycle, then access cycle until pready
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {pqs_pkg::REG_QUANTUM_LIMIT, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr)
			quantum_limit = wdata[7:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Read back the limit and compare with the mirror
	task automatic check_quantum_limit();
		logic [31:0] rd;
		apb_access(1'b0, 32'd0, rd);
		if (rd[7:0] !== quantum_limit) begin
			$error("quantum_limit readback: expected %0d, got %0d", quantum_limit, rd[7:0]);
			error_count++;
		end
	endtask

	// Only called with the block idle; upper bits of the write are noise
	task automatic write_quantum_limit(input logic [7:0] limit);
		logic [31:0] rd;
		apb_access(1'b1, {24'($urandom_range(0, 32'hFF_FFFF)), limit}, rd);
		check_quantum_limit();
	endtask

	function automatic void compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		sched_event_t want;
		if (m_tvalid && m_tready) begin
			if (m_tuser <= pqs_pkg::EV_IDLE)
				ev_seen[m_tuser]++;
			if (pending_events.size() == 0) begin
				$error("result with nothing expected: event_res %0d event_task %0d",
					m_tuser, m_tdata[7:0]);
				error_count++;
			end else begin
				want = pending_events.pop_front();
				compare_field("event_res", 8'(want.ev), 8'(m_tuser));
				compare_field("event_task", want.tid, m_tdata[7:0]);
				compare_field("work_left", want.work, m_tdata[15:8]);
				compare_field("quantum_used", want.quantum, m_tdata[23:16]);
				compare_field("last", 8'(want.last), 8'(m_tlast));
			end
		end
	end

	// Result receiver: random stalls, or one long hold when asked
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				m_tready = 1'b0;
				repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
				sink_hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (sink_idle_en && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog: ends the run after too long without any accepted item
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("priority_quantum_scheduler_unit_tb failed");
		$finish;
	end

	// Idle tick, adds at the field extremes, fill to the admission bound, reject,
	// preempt, finish with zero work, and the zero quantum limit
	task automatic test_directed();
		check_quantum_limit();
		write_quantum_limit(8'd1);
		send_item(pqs_pkg::MODE_TICK, 8'h5A, 3'd5, 8'hA5);
		send_item(pqs_pkg::MODE_ADD, 8'd0, 3'd7, 8'd255);
		send_item(pqs_pkg::MODE_TICK, 8'd0, 3'd0, 8'd0);
		send_item(pqs_pkg::MODE_ADD, 8'd255, 3'd0, 8'd0);
		send_item(pqs_pkg::MODE_ADD, 8'd1, 3'd3, 8'd2);
		send_item(pqs_pkg::MODE_ADD, 8'd2, 3'd3, 8'd1);
		send_item(pqs_pkg::MODE_ADD, 8'd3, 3'd0, 8'd5);
		for (int i = 0; i < 11; i++)
			send_item(pqs_pkg::MODE_ADD, 8'(8'h10 + i), 3'(i % 8), 8'(i));
		// queue plus running task is now full
		send_item(pqs_pkg::MODE_ADD, 8'hAA, 3'd0, 8'h55);
		send_item(pqs_pkg::MODE_TICK, 8'hFF, 3'd7, 8'hFF);
		send_item(pqs_pkg::MODE_TICK, 8'd0, 3'd0, 8'd0);
		send_item(pqs_pkg::MODE_TICK, 8'd0, 3'd0, 8'd0);
		wait_drained();
		write_quantum_limit(8'd0);
		send_item(pqs_pkg::MODE_TICK, 8'd0, 3'd0, 8'd0);
		send_item(pqs_pkg::MODE_TICK, 8'd0, 3'd0, 8'd0);
		wait_drained();
	endtask

	task automatic run_random_phase(input logic [7:0] limit, input int n_items,
		input int add_pct, input int work_max);
		wait_drained();
		write_quantum_limit(limit);
		repeat (n_items)
			send_random_item(add_pct, work_max);
	endtask

	// Random mixes of adds and ticks under several quantum limits
	task automatic test_random_scheduling();
		run_random_phase(8'd1, 170, 55, 6);
		run_random_phase(8'd255, 180, 45, 20);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		run_random_phase(8'($urandom_range(2, 12)), 200, 50, 10);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		run_random_phase(8'd0, 100, 50, 8);
		run_random_phase(8'($urandom_range(1, 255)), 200, 35, 8);
		run_random_phase(8'd3, 150, 65, 12);
		wait_drained();
	endtask

	// Long receiver hold while items keep coming, then a full drain
	task automatic test_backpressure();
		src_idle_en = 1'b0;
		sink_hold_req = 1'b1;
		repeat (60)
			send_random_item(50, 6);
		src_idle_en = 1'b1;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pqs_pkg::MODE_ADD;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_scheduling();
		test_backpressure();
		wait_drained();

		$display("Ran %0d items (%0d adds, %0d ticks) with quantum limits 0, 1, 3, 255 and random",
			adds_sent + ticks_sent, adds_sent, ticks_sent);
		$display("Results: dispatched %0d preempted %0d finished %0d ran %0d added %0d %s %0d idle %0d",
			ev_seen[pqs_pkg::EV_DISPATCHED], ev_seen[pqs_pkg::EV_PREEMPTED],
			ev_seen[pqs_pkg::EV_FINISHED], ev_seen[pqs_pkg::EV_RAN],
			ev_seen[pqs_pkg::EV_ADDED], "rejected", ev_seen[pqs_pkg::EV_REJECTED],
			ev_seen[pqs_pkg::EV_IDLE]);
		if (error_count == 0 && pending_events.size() == 0) begin
			$display("priority_quantum_scheduler_unit_tb passed");
		end else begin
			$display("priority_quantum_scheduler_unit_tb failed");
		end
		$finish;
	end

endmodule

// ===== priority_quantum_scheduler_unit.f =====
hdl/pqs_pkg.sv
hdl/priority_quantum_scheduler_unit.sv
test/priority_quantum_scheduler_unit_tb.sv
